FILE: src/chlx_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// chlx_pkg
// Shared types, constants and pin-pair tables for the charlieplexed scanner.
// ----------------------------------------------------------------------------
package chlx_pkg;

  // field widths
  localparam int unsigned DataW   = 8;
  localparam int unsigned PinW    = 4;
  localparam int unsigned SlotW   = 4;
  localparam int unsigned ChaseW  = 4;
  localparam int unsigned CfgIdxW = 2;

  // reset values and slot codes
  localparam logic [DataW-1:0]  ScanHoldReset    = 8'd1;
  localparam logic [DataW-1:0]  ChasePeriodReset = 8'd250;
  localparam logic [SlotW-1:0]  ScanSlotReset    = 4'd8;
  localparam logic [SlotW-1:0]  SlotZeroCode     = 4'd12;
  localparam logic [SlotW-1:0]  SlotFirstValid   = 4'd1;
  localparam logic [SlotW-1:0]  SlotLastValid    = 4'd11;
  localparam logic [SlotW-1:0]  SlotLowCount     = 4'd8;
  localparam logic [ChaseW-1:0] ChaseFirst       = 4'b0001;

  // item kind
  typedef enum logic {
    ReqTick   = 1'b0,
    ReqSample = 1'b1
  } req_type_e;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    RegScanHold    = 2'd0,
    RegChasePeriod = 2'd1
  } cfg_reg_e;

  // one input item
  typedef struct packed {
    req_type_e        req_type;
    logic [DataW-1:0] sample;
  } item_t;

  // one result item
  typedef struct packed {
    logic [PinW-1:0]  pin_enable;
    logic [PinW-1:0]  pin_high;
    logic [SlotW-1:0] lit_slot;
  } result_t;

  // driven pins per slot
  function automatic logic [PinW-1:0] slot_enable(input logic [SlotW-1:0] slot);
    logic [PinW-1:0] r;
    case (slot)
      4'd0, 4'd1:   r = 4'hC;
      4'd2, 4'd3:   r = 4'h6;
      4'd4, 4'd5:   r = 4'hA;
      4'd6, 4'd7:   r = 4'h3;
      4'd8, 4'd9:   r = 4'h9;
      4'd10, 4'd11: r = 4'h5;
      default:      r = 4'h0;
    endcase
    return r;
  endfunction

  // high pin per slot
  function automatic logic [PinW-1:0] slot_high(input logic [SlotW-1:0] slot);
    logic [PinW-1:0] r;
    case (slot)
      4'd0:    r = 4'h4;
      4'd1:    r = 4'h8;
      4'd2:    r = 4'h4;
      4'd3:    r = 4'h2;
      4'd4:    r = 4'h8;
      4'd5:    r = 4'h2;
      4'd6:    r = 4'h2;
      4'd7:    r = 4'h1;
      4'd8:    r = 4'h8;
      4'd9:    r = 4'h1;
      4'd10:   r = 4'h4;
      4'd11:   r = 4'h1;
      default: r = 4'h0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: src/charlieplex_led_scanner.sv
`default_nettype none
// ----------------------------------------------------------------------------
// charlieplex_led_scanner
// Twelve LEDs on four tri-state pins: ticks scan the slots, samples set the
// pattern for LEDs 0-7 and step a one-hot chase on LEDs 8-11.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+----------------------------------
//  in      | input     | in_valid_i/in_stall_o | req_type_i, sample_i
//  out     | output    | out_valid_o/out_stall_i | pin_enable_o, pin_high_o, lit_slot_o
//  cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
//  one item per cycle sustained while the output is not stalled; an accepted item
//  passes the input register, then next-state logic into the result register
//  reset loads the reset values; the first scan slot after reset is 7, pins float
//  a stalled output holds its result; the input keeps accepting while the
//  input register is empty or moving into the result register
//  configuration writes are taken every cycle
// ----------------------------------------------------------------------------
module charlieplex_led_scanner (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic                         req_type_i,
  input  wire logic [chlx_pkg::DataW-1:0]   sample_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [chlx_pkg::PinW-1:0]         pin_enable_o,
  output logic [chlx_pkg::PinW-1:0]         pin_high_o,
  output logic [chlx_pkg::SlotW-1:0]        lit_slot_o,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [chlx_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [chlx_pkg::DataW-1:0]   cfg_data_i
);

  logic              item_valid;
  logic              take;
  chlx_pkg::item_t   item;
  chlx_pkg::result_t result;

  // configuration always accepted
  assign cfg_ready_o = 1'b1;

  // input register
  chlx_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .req_type_i   (req_type_i),
    .sample_i     (sample_i),
    .take_i       (take),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  // scanner state and result register
  chlx_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .take_o       (take),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .result_o     (result)
  );

  assign pin_enable_o = result.pin_enable;
  assign pin_high_o   = result.pin_high;
  assign lit_slot_o   = result.lit_slot;

endmodule
`default_nettype wire

FILE: src/chlx_in_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// chlx_in_stage
// Input register: captures one item and holds it until the core takes it.
// ----------------------------------------------------------------------------
module chlx_in_stage (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic                       req_type_i,
  input  wire logic [chlx_pkg::DataW-1:0] sample_i,
  input  wire logic                       take_i,
  output logic                            item_valid_o,
  output chlx_pkg::item_t                 item_o
);

  logic            valid_q, valid_d;
  chlx_pkg::item_t item_q;

  // stall only while a held item is not being taken
  assign in_stall_o = valid_q && !take_i;

  // occupancy
  always_comb begin
    valid_d = valid_q;
    if (!in_stall_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload capture
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      item_q.req_type <= chlx_pkg::req_type_e'(req_type_i);
      item_q.sample   <= sample_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule
`default_nettype wire

FILE: src/chlx_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// chlx_core
// Scanner state, configuration registers, next-state logic and result register.
// ----------------------------------------------------------------------------
module chlx_core (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         item_valid_i,
  input  wire chlx_pkg::item_t              item_i,
  output logic                              take_o,
  input  wire logic                         cfg_valid_i,
  input  wire logic [chlx_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [chlx_pkg::DataW-1:0]   cfg_data_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output chlx_pkg::result_t                 result_o
);

  logic [chlx_pkg::DataW-1:0]  scan_hold_q, chase_period_q;
  logic [chlx_pkg::DataW-1:0]  low_pattern_q, low_pattern_d;
  logic [chlx_pkg::ChaseW-1:0] chase_pattern_q, chase_pattern_d, chase_shift;
  logic [chlx_pkg::DataW-1:0]  chase_countdown_q, chase_countdown_d;
  logic [chlx_pkg::SlotW-1:0]  scan_slot_q, scan_slot_d, next_slot;
  logic [chlx_pkg::DataW-1:0]  hold_counter_q, hold_counter_d;
  logic [chlx_pkg::PinW-1:0]   drive_enable_q, drive_enable_d;
  logic [chlx_pkg::PinW-1:0]   drive_high_q, drive_high_d;
  logic                        out_valid_q, out_valid_d;
  logic                        lit;
  chlx_pkg::result_t           result_q, result_d;

  // take the held item when the result register is free or draining
  assign take_o = item_valid_i && (!out_valid_q || !out_stall_i);

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_hold_q    <= chlx_pkg::ScanHoldReset;
      chase_period_q <= chlx_pkg::ChasePeriodReset;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == chlx_pkg::RegScanHold) begin
        scan_hold_q <= cfg_data_i;
      end
      if (cfg_index_i == chlx_pkg::RegChasePeriod) begin
        chase_period_q <= cfg_data_i;
      end
    end
  end

  // candidate scan slot: step down, slot zero kept as twelve
  always_comb begin
    next_slot = scan_slot_q - 4'd1;
    if (next_slot < chlx_pkg::SlotFirstValid || next_slot > chlx_pkg::SlotLastValid) begin
      next_slot = '0;
    end
    if (next_slot < chlx_pkg::SlotLowCount) begin
      lit = low_pattern_q[next_slot[2:0]];
    end else begin
      lit = chase_pattern_q[next_slot[1:0]];
    end
  end

  assign chase_shift = {chase_pattern_q[chlx_pkg::ChaseW-2:0], 1'b0};

  // next state for one item
  always_comb begin
    low_pattern_d     = low_pattern_q;
    chase_pattern_d   = chase_pattern_q;
    chase_countdown_d = chase_countdown_q;
    scan_slot_d       = scan_slot_q;
    hold_counter_d    = hold_counter_q;
    drive_enable_d    = drive_enable_q;
    drive_high_d      = drive_high_q;
    case (item_i.req_type)
      chlx_pkg::ReqSample: begin
        low_pattern_d = item_i.sample;
        if (chase_countdown_q == '0) begin
          chase_countdown_d = chase_period_q;
          chase_pattern_d   = (chase_shift == '0) ? chlx_pkg::ChaseFirst : chase_shift;
        end
      end
      chlx_pkg::ReqTick: begin
        if (chase_countdown_q != '0) begin
          chase_countdown_d = chase_countdown_q - 8'd1;
        end
        if (hold_counter_q == '0) begin
          hold_counter_d = scan_hold_q;
          scan_slot_d    = (next_slot == '0) ? chlx_pkg::SlotZeroCode : next_slot;
          drive_enable_d = lit ? chlx_pkg::slot_enable(next_slot) : '0;
          drive_high_d   = lit ? chlx_pkg::slot_high(next_slot) : '0;
        end else begin
          hold_counter_d = hold_counter_q - 8'd1;
        end
      end
      default: begin
        low_pattern_d = low_pattern_q;
      end
    endcase
  end

  // result of the item
  always_comb begin
    result_d.pin_enable = drive_enable_d;
    result_d.pin_high   = drive_high_d & drive_enable_d;
    result_d.lit_slot   = (scan_slot_d == chlx_pkg::SlotZeroCode) ? '0 : scan_slot_d;
  end

  // result register occupancy
  always_comb begin
    out_valid_d = out_valid_q;
    if (take_o) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_pattern_q     <= '0;
      chase_pattern_q   <= '0;
      chase_countdown_q <= '0;
      scan_slot_q       <= chlx_pkg::ScanSlotReset;
      hold_counter_q    <= '0;
      drive_enable_q    <= '0;
      drive_high_q      <= '0;
      out_valid_q       <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (take_o) begin
        low_pattern_q     <= low_pattern_d;
        chase_pattern_q   <= chase_pattern_d;
        chase_countdown_q <= chase_countdown_d;
        scan_slot_q       <= scan_slot_d;
        hold_counter_q    <= hold_counter_d;
        drive_enable_q    <= drive_enable_d;
        drive_high_q      <= drive_high_d;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (take_o) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

`ifndef NO_ASSERTIONS
  // scan slot stays within its stored codes
  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (scan_slot_q >= chlx_pkg::SlotFirstValid) && (scan_slot_q <= chlx_pkg::SlotZeroCode))
    else $error("scan slot out of range");

  // a high pin is always a driven pin
  a_high_driven: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (drive_high_q & ~drive_enable_q) == '0)
    else $error("high pin not driven");

  // either all pins float or exactly one pair is driven
  a_pair_driven: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (drive_enable_q == '0) || ($countones(drive_enable_q) == 2))
    else $error("drive is not a pin pair");

  // chase pattern has at most one bit set
  a_chase_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(chase_pattern_q))
    else $error("chase pattern not one-hot");

  // a sample item leaves the pin drive alone
  a_sample_keeps_drive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take_o && item_i.req_type == chlx_pkg::ReqSample)
      |=> ($stable(drive_enable_q) && $stable(drive_high_q)))
    else $error("sample item changed the drive");
`endif

endmodule
`default_nettype wire

FILE: tb/sv/scan_drive_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scan_drive_checker
// Watches the item, result and register channels of the LED scanner, keeps
// its own copy of the scan, pattern and chase state, works out the pin drive
// for every accepted item and compares it with the result, oldest first.
// ----------------------------------------------------------------------------
module scan_drive_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  logic                         req_type_i,
  input  logic [chlx_pkg::DataW-1:0]   sample_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  logic [chlx_pkg::PinW-1:0]    pin_enable_i,
  input  logic [chlx_pkg::PinW-1:0]    pin_high_i,
  input  logic [chlx_pkg::SlotW-1:0]   lit_slot_i,
  input  logic                         cfg_valid_i,
  input  logic                         cfg_ready_i,
  input  logic [chlx_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [chlx_pkg::DataW-1:0]   cfg_data_i,
  output int unsigned                  fail_count_o,
  output int unsigned                  pending_o
);
  import chlx_pkg::*;

  localparam int unsigned ReportLimit = 10;

  // pin pair per slot, slot 0 in the low nibble
  localparam logic [12*PinW-1:0] PairEnableMap =
    {4'h5, 4'h5, 4'h9, 4'h9, 4'h3, 4'h3, 4'hA, 4'hA, 4'h6, 4'h6, 4'hC, 4'hC};
  localparam logic [12*PinW-1:0] PairHighMap =
    {4'h1, 4'h4, 4'h1, 4'h8, 4'h1, 4'h2, 4'h2, 4'h8, 4'h2, 4'h4, 4'h8, 4'h4};

  // predicted scanner state and settings
  logic [DataW-1:0]  hold_cfg;
  logic [DataW-1:0]  period_cfg;
  logic [DataW-1:0]  leds_low;
  logic [ChaseW-1:0] chase_leds;
  logic [DataW-1:0]  countdown;
  logic [SlotW-1:0]  cur_slot;
  logic [DataW-1:0]  hold_left;
  logic [PinW-1:0]   pins_en;
  logic [PinW-1:0]   pins_hi;

  result_t expected_drive[$];

  // one item through the scanner state, giving the drive seen after it
  task automatic step_scanner(input req_type_e kind, input logic [DataW-1:0] smp,
                              output result_t res);
    logic [SlotW-1:0] next_slot;
    logic [SlotW-1:0] chase_idx;
    logic             led_on;
    if (kind == ReqSample) begin
      leds_low = smp;
      if (countdown == '0) begin
        countdown  = period_cfg;
        chase_leds = chase_leds << 1;
        if (chase_leds == '0) chase_leds = ChaseFirst;
      end
    end else begin
      if (countdown != '0) countdown = countdown - 8'd1;
      if (hold_left == '0) begin
        hold_left = hold_cfg;
        next_slot = cur_slot - 4'd1;
        // slot 0 is kept as its own code so that the next step wraps to 11
        if (next_slot < SlotFirstValid || next_slot > SlotLastValid) begin
          next_slot = '0;
          cur_slot  = SlotZeroCode;
        end else begin
          cur_slot = next_slot;
        end
        chase_idx = next_slot - SlotLowCount;
        led_on = (next_slot < SlotLowCount) ? leds_low[next_slot[2:0]]
                                            : chase_leds[chase_idx[1:0]];
        if (led_on) begin
          pins_en = PairEnableMap[next_slot*PinW +: PinW];
          pins_hi = PairHighMap[next_slot*PinW +: PinW];
        end else begin
          pins_en = '0;
          pins_hi = '0;
        end
      end else begin
        hold_left = hold_left - 8'd1;
      end
    end
    res.pin_enable = pins_en;
    res.pin_high   = pins_hi & pins_en;
    res.lit_slot   = (cur_slot == SlotZeroCode) ? '0 : cur_slot;
  endtask

  // watch all three channels; results are checked before new items go in
  always @(posedge clk_i or negedge rst_ni) begin : watch
    result_t want;
    result_t got;
    if (!rst_ni) begin
      hold_cfg   = ScanHoldReset;
      period_cfg = ChasePeriodReset;
      leds_low   = '0;
      chase_leds = '0;
      countdown  = '0;
      cur_slot   = ScanSlotReset;
      hold_left  = '0;
      pins_en    = '0;
      pins_hi    = '0;
      expected_drive.delete();
      fail_count_o = 0;
    end else begin
      // register writes
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_reg_e'(cfg_index_i))
          RegScanHold:    hold_cfg = cfg_data_i;
          RegChasePeriod: period_cfg = cfg_data_i;
          default: ;
        endcase
      end
      // results against the oldest expectation
      if (out_valid_i && !out_stall_i) begin
        got.pin_enable = pin_enable_i;
        got.pin_high   = pin_high_i;
        got.lit_slot   = lit_slot_i;
        if (expected_drive.size() == 0) begin
          if (fail_count_o < ReportLimit)
            $display("%0t scanner: result with none pending, got en=%h hi=%h slot=%0d",
                     $time, got.pin_enable, got.pin_high, got.lit_slot);
          fail_count_o++;
        end else begin
          want = expected_drive.pop_front();
          if (got.pin_enable !== want.pin_enable || got.pin_high !== want.pin_high ||
              got.lit_slot !== want.lit_slot) begin
            if (fail_count_o < ReportLimit)
              $display("%0t scanner mismatch: expected en=%h hi=%h slot=%0d, got en=%h hi=%h slot=%0d",
                       $time, want.pin_enable, want.pin_high, want.lit_slot,
                       got.pin_enable, got.pin_high, got.lit_slot);
            fail_count_o++;
          end
        end
      end
      // accepted items
      if (in_valid_i && !in_stall_i) begin
        step_scanner(req_type_e'(req_type_i), sample_i, want);
        expected_drive.push_back(want);
      end
    end
    pending_o = expected_drive.size();
  end

endmodule

FILE: tb/sv/tb_charlieplex_led_scanner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_charlieplex_led_scanner
// Drives ticks and samples into the LED scanner under a series of hold and
// chase settings, with random gaps and output stalls, and lets the checker
// compare every pin drive result.
// ----------------------------------------------------------------------------
module tb_charlieplex_led_scanner;
  import chlx_pkg::*;

  localparam int unsigned CycleLimit  = 300000;
  localparam int unsigned SettleWait  = 4;
  localparam int unsigned TailWait    = 10;
  localparam int unsigned PhaseCount  = 7;
  localparam int unsigned PhaseItems  = 200;
  localparam logic [CfgIdxW-1:0] RegSpareLow  = 2'd2;
  localparam logic [CfgIdxW-1:0] RegSpareHigh = 2'd3;

  logic                clk_i  = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i;
  logic                in_stall_o;
  req_type_e           req_type_i;
  logic [DataW-1:0]    sample_i;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [PinW-1:0]     pin_enable_o;
  logic [PinW-1:0]     pin_high_o;
  logic [SlotW-1:0]    lit_slot_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [DataW-1:0]    cfg_data_i;

  int unsigned mismatch_total;
  int unsigned results_owed;
  int unsigned cycle_count = 0;
  int unsigned stall_left  = 0;
  bit          gaps_on     = 1'b0;
  bit          stall_on    = 1'b0;
  bit          quiet_tail  = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  charlieplex_led_scanner dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .req_type_i   (req_type_i),
    .sample_i     (sample_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .pin_enable_o (pin_enable_o),
    .pin_high_o   (pin_high_o),
    .lit_slot_o   (lit_slot_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  scan_drive_checker checker_inst (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .req_type_i   (req_type_i),
    .sample_i     (sample_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .pin_enable_i (pin_enable_o),
    .pin_high_i   (pin_high_o),
    .lit_slot_i   (lit_slot_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (mismatch_total),
    .pending_o    (results_owed)
  );

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // output stalls in random bursts
  always @(posedge clk_i) begin
    if (quiet_tail || !stall_on) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
    end else if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= stall_left - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= $urandom_range(0, 8);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // one item, with an optional gap before it; valid stays high afterwards
  task automatic send_item(input req_type_e kind, input logic [DataW-1:0] smp);
    if (gaps_on && !quiet_tail && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= kind;
    sample_i   <= smp;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // stop sending and wait until every result is back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (results_owed != 0);
    repeat (SettleWait) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // one register write; valid is left high for a following write
  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [DataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  // both registers, optionally followed by writes to the unused indexes
  task automatic set_config(input logic [DataW-1:0] hold, input logic [DataW-1:0] period,
                            input bit spare);
    cfg_write(RegScanHold, hold);
    cfg_write(RegChasePeriod, period);
    if (spare) begin
      cfg_write(RegSpareLow, DataW'($urandom_range(0, 255)));
      cfg_write(RegSpareHigh, DataW'($urandom_range(0, 255)));
    end
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // random ticks and samples, with an occasional full drain
  task automatic random_items(input int unsigned count);
    req_type_e        kind;
    logic [DataW-1:0] smp;
    int unsigned      pick;
    for (int unsigned i = 0; i < count; i++) begin
      kind = ($urandom_range(0, 2) == 0) ? ReqSample : ReqTick;
      pick = $urandom_range(0, 7);
      smp  = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : DataW'($urandom);
      send_item(kind, smp);
      if ($urandom_range(0, 149) == 0) drain_results();
    end
  endtask

  initial begin
    logic [DataW-1:0] hold_val;
    logic [DataW-1:0] period_val;
    in_valid_i  <= 1'b0;
    req_type_i  <= ReqTick;
    sample_i    <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= RegScanHold;
    cfg_data_i  <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    gaps_on  = 1'b1;
    stall_on = 1'b1;

    // reset settings: nothing scanned yet, then first slot 7 with hold of one
    send_item(ReqSample, 8'h00);
    send_item(ReqTick, 8'hFF);
    send_item(ReqSample, 8'hA5);
    send_item(ReqTick, 8'h00);
    send_item(ReqTick, 8'h00);
    send_item(ReqTick, 8'hFF);
    drain_results();

    // no hold: walk every slot, through slot 0 and the wrap to 11
    set_config(8'd0, 8'd0, 1'b1);
    send_item(ReqSample, 8'hFF);
    for (int unsigned k = 0; k < 7; k++) send_item(ReqTick, 8'h00);
    send_item(ReqSample, 8'h00);
    send_item(ReqTick, 8'hFF);
    send_item(ReqSample, 8'h01);
    send_item(ReqTick, 8'h00);
    send_item(ReqTick, 8'h00);
    send_item(ReqTick, 8'h00);
    send_item(ReqTick, 8'h00);
    send_item(ReqTick, 8'h00);

    // random phases across the settings range, idling off in one and at the end
    for (int unsigned p = 0; p < PhaseCount; p++) begin
      drain_results();
      case (p)
        0: begin hold_val = 8'd0;   period_val = 8'd1;   end
        1: begin hold_val = 8'd3;   period_val = 8'd2;   end
        2: begin hold_val = 8'd0;   period_val = 8'd0;   end
        3: begin hold_val = 8'd255; period_val = 8'd255; end
        4: begin hold_val = 8'd1;   period_val = 8'd250; end
        default: begin
          hold_val   = DataW'($urandom_range(0, 4));
          period_val = DataW'($urandom_range(0, 6));
        end
      endcase
      set_config(hold_val, period_val, p == 3);
      gaps_on    = (p != 2);
      stall_on   = (p != 2);
      quiet_tail = (p == PhaseCount - 1);
      random_items(PhaseItems);
    end

    drain_results();
    repeat (TailWait) @(posedge clk_i);
    if (mismatch_total == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
